/* sv/page_framebuffer_draw_engine_top_macros.svh */
// assertion macros used by the draw engine back end
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PFDE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PFDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pfde_pkg.sv */
// shared constants, command codes and types of the draw engine
package pfde_pkg;

	localparam int RAM_COLUMNS    = 132;
	localparam int ROWS           = 64;
	localparam int COLUMN_OFFSET  = 2;
	localparam int MAX_THICKNESS  = 15;
	localparam int PAGES          = ROWS / 8;
	localparam int STORE_DEPTH    = PAGES * RAM_COLUMNS;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int PAGE_W         = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int SP_W           = $clog2(PAGES + 1);
	localparam int COL_BITS       = PAGES * 8;
	localparam int LINE_COORD_MAX = 127;
	localparam int LINE_COL_LIMIT = 128;
	localparam int LINE_ROW_LIMIT = 64;
	localparam int CRD_W          = 10;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [2:0] FUNC_LINE   = 3'd0;
	localparam logic [2:0] FUNC_RECT   = 3'd1;
	localparam logic [2:0] FUNC_SDOWN  = 3'd2;
	localparam logic [2:0] FUNC_SUP    = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;
	localparam logic [2:0] FUNC_READ   = 3'd5;

	typedef enum logic [2:0] {
		OP_LINE,
		OP_RECT,
		OP_SCROLL,
		OP_CLEAR,
		OP_READ,
		OP_REJECT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] xa;
		logic [5:0] ya;
		logic [7:0] xb;
		logic [6:0] yb;
		logic [2:0] half;
		logic       thick_nz;
		logic       color;
		logic       down;
		logic [6:0] rows;
		logic       wipe;
		logic [2:0] page;
		logic [6:0] el;
		logic [6:0] es;
		logic       incx_neg;
		logic       incy_neg;
		logic       major;
	} cmd_t;

	typedef enum logic [3:0] {
		B_INIT,
		B_IDLE,
		B_CLEAR,
		B_PRD,
		B_PWR,
		B_LSTEP,
		B_LCTR,
		B_LPERP,
		B_RECT,
		B_SRD,
		B_SSH,
		B_SWR,
		B_BRD,
		B_BCAP,
		B_RESP
	} bstate_t;

endpackage

/* sv/page_framebuffer_draw_engine_top.sv */
// top level of the page-organised frame store draw engine
//
//  channel   direction  handshake              payload
//  command   in         start & !busy          func x_a y_a x_b y_b thickness color
//                                              scroll_rows page
//  result    out        done (one cycle)       status read_byte
//
// after reset a clearing pass writes all 1056 bytes, one a cycle, with busy high
// a drawn pixel passes the select, ram read and modify-and-write states, a clipped one
// only the select state; a scroll reads, shifts and writes back each column in turn,
// clear writes every byte, readback reads and captures one byte
// busy rises when the two-entry command queue is full, so a command may be given
// while an earlier one is still drawing; the result receiver cannot stall
module page_framebuffer_draw_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] func,
	input  logic [7:0] x_a,
	input  logic [5:0] y_a,
	input  logic [7:0] x_b,
	input  logic [6:0] y_b,
	input  logic [3:0] thickness,
	input  logic       color,
	input  logic [6:0] scroll_rows,
	input  logic [2:0] page,
	output logic       done,
	output logic       status,
	output logic [7:0] read_byte
);
	import pfde_pkg::*;

	cmd_t fe_cmd, q_head;
	logic push, pop, q_avail, q_full, init_busy;

	pfde_front u_front (
		.start       (start),
		.q_full      (q_full),
		.init_busy   (init_busy),
		.func        (func),
		.x_a         (x_a),
		.y_a         (y_a),
		.x_b         (x_b),
		.y_b         (y_b),
		.thickness   (thickness),
		.color       (color),
		.scroll_rows (scroll_rows),
		.page        (page),
		.busy        (busy),
		.push        (push),
		.cmd         (fe_cmd)
	);

	pfde_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (fe_cmd),
		.pop    (pop),
		.head   (q_head),
		.avail  (q_avail),
		.full   (q_full)
	);

	pfde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.avail     (q_avail),
		.pop       (pop),
		.init_busy (init_busy),
		.done      (done),
		.status    (status),
		.read_byte (read_byte)
	);
endmodule

/* sv/pfde_ram.sv */
// generic single-port ram with registered read
module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1056
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* sv/pfde_front.sv */
// command front end: accept handshake, bounds checks and line set-up
module pfde_front (
	input  logic           start,
	input  logic           q_full,
	input  logic           init_busy,
	input  logic [2:0]     func,
	input  logic [7:0]     x_a,
	input  logic [5:0]     y_a,
	input  logic [7:0]     x_b,
	input  logic [6:0]     y_b,
	input  logic [3:0]     thickness,
	input  logic           color,
	input  logic [6:0]     scroll_rows,
	input  logic [2:0]     page,
	output logic           busy,
	output logic           push,
	output pfde_pkg::cmd_t cmd
);
	import pfde_pkg::*;

	logic [7:0] dx;
	logic [6:0] dy;
	logic [4:0] thick_sat;
	logic       line_bad;
	logic       rect_bad;
	logic       read_bad;

	assign busy = q_full | init_busy;
	assign push = start & ~busy;

	always_comb begin
		dx = (x_b > x_a) ? (x_b - x_a) : (x_a - x_b);
		dy = (y_b > {1'b0, y_a}) ? (y_b - {1'b0, y_a}) : ({1'b0, y_a} - y_b);
		thick_sat = (int'(thickness) > MAX_THICKNESS) ? 5'(MAX_THICKNESS) : {1'b0, thickness};
		line_bad = (int'(x_a) > LINE_COORD_MAX) || (int'(x_b) > LINE_COORD_MAX)
			|| (int'(y_b) > LINE_COORD_MAX);
		rect_bad = (x_b == 8'd0) || (y_b == 7'd0) || (int'(x_a) > RAM_COLUMNS)
			|| (int'(x_a) + int'(x_b) > RAM_COLUMNS) || (int'(y_a) > ROWS)
			|| (int'(y_a) + int'(y_b) > ROWS);
		read_bad = (int'(x_a) >= RAM_COLUMNS) || (int'(page) >= PAGES);

		cmd.xa       = x_a;
		cmd.ya       = y_a;
		cmd.xb       = x_b;
		cmd.yb       = y_b;
		cmd.half     = thick_sat[3:1];
		cmd.thick_nz = (thick_sat != 5'd0);
		cmd.color    = color;
		cmd.down     = (func == FUNC_SDOWN);
		cmd.rows     = scroll_rows;
		cmd.wipe     = (int'(scroll_rows) >= COL_BITS);
		cmd.page     = page;
		cmd.major    = ({1'b0, dx[6:0]} > {1'b0, dy}) && (dx[7] == 1'b0);
		cmd.el       = cmd.major ? dx[6:0] : dy;
		cmd.es       = cmd.major ? dy : dx[6:0];
		cmd.incx_neg = !(x_a < x_b);
		cmd.incy_neg = !({1'b0, y_a} < y_b);

		case (func)
			FUNC_LINE:  cmd.op = line_bad ? OP_REJECT : OP_LINE;
			FUNC_RECT:  cmd.op = rect_bad ? OP_REJECT : OP_RECT;
			FUNC_SDOWN: cmd.op = OP_SCROLL;
			FUNC_SUP:   cmd.op = OP_SCROLL;
			FUNC_CLEAR: cmd.op = OP_CLEAR;
			FUNC_READ:  cmd.op = read_bad ? OP_REJECT : OP_READ;
			default:    cmd.op = OP_REJECT;
		endcase
	end
endmodule

/* sv/pfde_queue.sv */
// short command queue between front end and drawing back end
module pfde_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfde_pkg::cmd_t cmd_in,
	input  logic           pop,
	output pfde_pkg::cmd_t head,
	output logic           avail,
	output logic           full
);
	import pfde_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head  = slot_q[rd_q];
	assign avail = (cnt_q != '0);
	assign full  = (int'(cnt_q) == QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (int'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (int'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end
endmodule

/* sv/pfde_back.sv */
// drawing back end: line, rectangle, scroll, clear and readback over the frame ram
`include "page_framebuffer_draw_engine_top_macros.svh"
module pfde_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pfde_pkg::cmd_t head,
	input  logic           avail,
	output logic           pop,
	output logic           init_busy,
	output logic           done,
	output logic           status,
	output logic [7:0]     read_byte
);
	import pfde_pkg::*;

	bstate_t                 state_q, state_d, ret_d, ret_q;
	cmd_t                    cmd_q;
	logic [ADDR_W-1:0]       pix_addr_q;
	logic [2:0]              pix_bit_q;
	logic signed [CRD_W-1:0] lx_q, ly_q;
	logic signed [8:0]       err_q, err_e;
	logic [6:0]              t_q;
	logic [3:0]              j_q;
	logic                    side_q;
	logic [7:0]              rx_q;
	logic [6:0]              ry_q;
	logic [7:0]              sc_q;
	logic [SP_W-1:0]         sp_q;
	logic [COL_BITS-1:0]     v_q;
	logic [ADDR_W-1:0]       clr_q;
	logic [7:0]              rb_q;
	logic                    done_q, status_q;
	logic [7:0]              read_byte_q;

	logic signed [CRD_W-1:0] cand_x, cand_y, ix, iy, jv, sx, sy;
	logic                    cand_ok, extra, plot, rect_last, perp_end, clr_last;
	logic [PAGE_W-1:0]       cand_pg;
	logic [ADDR_W-1:0]       cand_addr, col_addr;
	logic [ADDR_W-1:0]       ram_addr;
	logic                    ram_we;
	logic [7:0]              ram_wdata, ram_rdata, bit_mask;
	logic [PAGE_W-1:0]       cap_idx;

	pfde_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign ix        = cmd_q.incx_neg ? -10'sd1 : 10'sd1;
	assign iy        = cmd_q.incy_neg ? -10'sd1 : 10'sd1;
	assign jv        = $signed({6'd0, j_q});
	assign sx        = cmd_q.major ? 10'sd0 : (cmd_q.incy_neg ? -jv : jv);
	assign sy        = cmd_q.major ? (cmd_q.incx_neg ? -jv : jv) : 10'sd0;
	assign err_e     = err_q - $signed({2'b00, cmd_q.es});
	assign rect_last = (rx_q == cmd_q.xb - 8'd1) && (ry_q == cmd_q.yb - 7'd1);
	assign perp_end  = (j_q > {1'b0, cmd_q.half});
	assign clr_last  = (int'(clr_q) == STORE_DEPTH - 1);
	assign cap_idx   = PAGE_W'(sp_q - 1'b1);
	assign col_addr  = ADDR_W'(int'(PAGE_W'(sp_q)) * RAM_COLUMNS) + ADDR_W'(sc_q);
	assign bit_mask  = 8'h01 << pix_bit_q;
	assign init_busy = (state_q == B_INIT);

	// pixel candidate for the current drawing step
	always_comb begin
		cand_x = lx_q;
		cand_y = ly_q;
		extra  = 1'b1;
		case (state_q)
			B_IDLE: begin
				cand_x = $signed({2'b00, head.xa});
				cand_y = $signed({4'b0000, head.ya});
			end
			B_LCTR: begin
				extra = (lx_q < LINE_COL_LIMIT) && (ly_q < LINE_ROW_LIMIT);
			end
			B_LPERP: begin
				cand_x = side_q ? (lx_q - sx) : (lx_q + sx);
				cand_y = side_q ? (ly_q + sy) : (ly_q - sy);
				extra  = (cand_x < RAM_COLUMNS) && (cand_y < ROWS);
			end
			B_RECT: begin
				cand_x = $signed({2'b00, cmd_q.xa}) + $signed({2'b00, rx_q});
				cand_y = $signed({4'b0000, cmd_q.ya}) + $signed({3'b000, ry_q});
			end
			default: begin
				extra = 1'b1;
			end
		endcase
		cand_ok = (cand_x >= 0) && (cand_y >= 0) && (cand_x + COLUMN_OFFSET < RAM_COLUMNS)
			&& (cand_y < ROWS) && extra;
		cand_pg   = cand_y[PAGE_W+2:3];
		cand_addr = ADDR_W'(int'(cand_pg) * RAM_COLUMNS) + ADDR_W'(cand_x + COLUMN_OFFSET);
	end

	// next state, ram port and queue pop
	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		plot      = 1'b0;
		pop       = 1'b0;
		ram_addr  = pix_addr_q;
		ram_we    = 1'b0;
		ram_wdata = 8'd0;
		case (state_q)
			B_INIT: begin
				ram_addr = clr_q;
				ram_we   = 1'b1;
				if (clr_last) begin
					state_d = B_IDLE;
				end
			end
			B_CLEAR: begin
				ram_addr = clr_q;
				ram_we   = 1'b1;
				if (clr_last) begin
					state_d = B_RESP;
				end
			end
			B_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					case (head.op)
						OP_LINE: begin
							plot    = 1'b1;
							ret_d   = B_LSTEP;
							state_d = B_PRD;
						end
						OP_RECT:   state_d = B_RECT;
						OP_SCROLL: state_d = B_SRD;
						OP_CLEAR:  state_d = B_CLEAR;
						OP_READ:   state_d = B_BRD;
						default:   state_d = B_RESP;
					endcase
				end
			end
			B_PRD: begin
				state_d = B_PWR;
			end
			B_PWR: begin
				ram_we    = 1'b1;
				ram_wdata = cmd_q.color ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
				state_d   = ret_q;
			end
			B_LSTEP: begin
				if (t_q == cmd_q.el) begin
					state_d = B_RESP;
				end else if (cmd_q.thick_nz) begin
					state_d = B_LCTR;
				end
			end
			B_LCTR: begin
				if (cand_ok) begin
					plot    = 1'b1;
					ret_d   = B_LPERP;
					state_d = B_PRD;
				end else begin
					state_d = B_LSTEP;
				end
			end
			B_LPERP: begin
				if (perp_end) begin
					state_d = B_LSTEP;
				end else if (cand_ok) begin
					plot    = 1'b1;
					ret_d   = B_LPERP;
					state_d = B_PRD;
				end
			end
			B_RECT: begin
				ret_d = rect_last ? B_RESP : B_RECT;
				if (cand_ok) begin
					plot    = 1'b1;
					state_d = B_PRD;
				end else begin
					state_d = ret_d;
				end
			end
			B_SRD: begin
				ram_addr = col_addr;
				if (int'(sp_q) == PAGES) begin
					state_d = B_SSH;
				end
			end
			B_SSH: begin
				state_d = B_SWR;
			end
			B_SWR: begin
				ram_addr  = col_addr;
				ram_we    = 1'b1;
				ram_wdata = v_q[8*PAGE_W'(sp_q) +: 8];
				if (int'(sp_q) == PAGES - 1) begin
					state_d = (int'(sc_q) == RAM_COLUMNS - 1) ? B_RESP : B_SRD;
				end
			end
			B_BRD: begin
				ram_addr = ADDR_W'(int'(cmd_q.page) * RAM_COLUMNS) + ADDR_W'(cmd_q.xa);
				state_d  = B_BCAP;
			end
			B_BCAP: begin
				state_d = B_RESP;
			end
			B_RESP: begin
				state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			ret_q   <= B_IDLE;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (plot) begin
				ret_q <= ret_d;
			end
			done_q <= (state_q == B_RESP);
			if (state_q == B_INIT || state_q == B_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
		end
	end

	// working registers of the drawing steps
	always_ff @(posedge clk) begin
		if (plot) begin
			pix_addr_q <= cand_addr;
			pix_bit_q  <= cand_y[2:0];
		end
		case (state_q)
			B_IDLE: begin
				if (avail) begin
					cmd_q <= head;
					lx_q  <= $signed({2'b00, head.xa});
					ly_q  <= $signed({4'b0000, head.ya});
					err_q <= $signed({3'b000, head.el[6:1]});
					t_q   <= '0;
					rx_q  <= '0;
					ry_q  <= '0;
					sc_q  <= '0;
					sp_q  <= '0;
				end
			end
			B_LSTEP: begin
				j_q    <= 4'd1;
				side_q <= 1'b0;
				if (t_q != cmd_q.el) begin
					t_q <= t_q + 7'd1;
					if (err_e < 0) begin
						err_q <= err_e + $signed({2'b00, cmd_q.el});
						lx_q  <= lx_q + ix;
						ly_q  <= ly_q + iy;
					end else begin
						err_q <= err_e;
						lx_q  <= lx_q + (cmd_q.major ? ix : 10'sd0);
						ly_q  <= ly_q + (cmd_q.major ? 10'sd0 : iy);
					end
				end
			end
			B_LPERP: begin
				if (!perp_end) begin
					if (side_q) begin
						j_q <= j_q + 4'd1;
					end
					side_q <= ~side_q;
				end
			end
			B_RECT: begin
				if (rx_q == cmd_q.xb - 8'd1) begin
					rx_q <= '0;
					ry_q <= ry_q + 7'd1;
				end else begin
					rx_q <= rx_q + 8'd1;
				end
			end
			B_SRD: begin
				if (sp_q != '0) begin
					v_q[8*cap_idx +: 8] <= ram_rdata;
				end
				if (int'(sp_q) != PAGES) begin
					sp_q <= sp_q + 1'b1;
				end
			end
			B_SSH: begin
				sp_q <= '0;
				if (cmd_q.wipe) begin
					v_q <= '0;
				end else if (cmd_q.down) begin
					v_q <= v_q << cmd_q.rows;
				end else begin
					v_q <= v_q >> cmd_q.rows;
				end
			end
			B_SWR: begin
				if (int'(sp_q) == PAGES - 1) begin
					sp_q <= '0;
					sc_q <= sc_q + 8'd1;
				end else begin
					sp_q <= sp_q + 1'b1;
				end
			end
			B_BCAP: begin
				rb_q <= ram_rdata;
			end
			B_RESP: begin
				status_q    <= (cmd_q.op == OP_REJECT);
				read_byte_q <= (cmd_q.op == OP_READ) ? rb_q : 8'd0;
			end
			default: begin
				rb_q <= rb_q;
			end
		endcase
	end

	assign done      = done_q;
	assign status    = status_q;
	assign read_byte = read_byte_q;

	`PFDE_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held for two cycles")
	`PFDE_ASSERT_IMPL(a_reject_zero, done_q && status_q, read_byte_q == 8'd0, "rejected result carries data")
	`PFDE_ASSERT_IMPL(a_no_pop_init, state_q == B_INIT, !pop, "command taken during clearing pass")
	`PFDE_ASSERT_IMPL(a_write_range, ram_we, int'(ram_addr) < STORE_DEPTH, "frame write out of range")
endmodule

/* tb/sv/page_framebuffer_draw_engine_top_test.sv */
// self-checking testbench of the page frame store draw engine
module page_framebuffer_draw_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pfde_pkg::*;

	typedef struct {
		logic [2:0] func;
		logic [7:0] xa;
		logic [5:0] ya;
		logic [7:0] xb;
		logic [6:0] yb;
		logic [3:0] thick;
		logic       color;
		logic [6:0] rows;
		logic [2:0] page;
		bit         typed;
		logic       t_status;
		logic [7:0] t_byte;
	} draw_cmd_t;

	typedef struct {
		logic       status;
		logic [7:0] rbyte;
	} draw_result_t;

	localparam logic [2:0] FUNC_BAD6 = 3'd6;
	localparam logic [2:0] FUNC_BAD7 = 3'd7;
	localparam int N_RANDOM = 580;
	localparam int CALM_TAIL = 60;

	logic clk, arst_n, start, busy, done, status, color;
	logic [2:0] func, page;
	logic [7:0] x_a, x_b, read_byte;
	logic [5:0] y_a;
	logic [6:0] y_b, scroll_rows;
	logic [3:0] thickness;

	page_framebuffer_draw_engine_top dut (.*);

	logic [7:0] shadow_store [STORE_DEPTH];
	draw_result_t pending_results[$];
	int errors, n_sent, n_checked, n_reads, n_lines, n_rejects;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("page_framebuffer_draw_engine_top: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("result %0d: %s got %0h want %0h", n_checked, what, got, want);
	endtask

	function automatic void plot(input int x, input int y, input logic c);
		int col;
		int idx;
		col = x + COLUMN_OFFSET;
		if (x < 0 || y < 0 || col >= RAM_COLUMNS || y >= ROWS) return;
		idx = (y >> 3) * RAM_COLUMNS + col;
		shadow_store[idx][y & 7] = c;
	endfunction

	function automatic logic trace_line(input int x1, input int y1, input int x2, input int y2,
		input int thick, input logic c);
		int dx, dy, incx, incy, x, y, pdx, pdy, es, el, err, t, j;
		if (x1 > LINE_COORD_MAX || y1 > LINE_COORD_MAX || x2 > LINE_COORD_MAX ||
			y2 > LINE_COORD_MAX) return 1'b1;
		if (thick > MAX_THICKNESS) thick = MAX_THICKNESS;
		dx = x2 > x1 ? x2 - x1 : x1 - x2;
		dy = y2 > y1 ? y2 - y1 : y1 - y2;
		incx = x1 < x2 ? 1 : -1;
		incy = y1 < y2 ? 1 : -1;
		if (dx > dy) begin
			pdx = incx; pdy = 0; es = dy; el = dx;
		end else begin
			pdx = 0; pdy = incy; es = dx; el = dy;
		end
		err = el / 2;
		x = x1;
		y = y1;
		plot(x1, y1, c);
		for (t = 0; t < el; t++) begin
			err -= es;
			if (err < 0) begin
				err += el; x += incx; y += incy;
			end else begin
				x += pdx; y += pdy;
			end
			if (thick < 1) continue;
			if (x >= 0 && x < LINE_COL_LIMIT && y >= 0 && y < LINE_ROW_LIMIT) begin
				plot(x, y, c);
				for (j = 1; j <= thick / 2; j++) begin
					if (x + j*pdy >= 0 && x + j*pdy < RAM_COLUMNS && y - j*pdx >= 0 &&
						y - j*pdx < ROWS) plot(x + j*pdy, y - j*pdx, c);
					if (x - j*pdy >= 0 && x - j*pdy < RAM_COLUMNS && y + j*pdx >= 0 &&
						y + j*pdx < ROWS) plot(x - j*pdy, y + j*pdx, c);
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic draw_result_t apply_cmd(input draw_cmd_t cmd);
		draw_result_t r;
		logic [COL_BITS-1:0] column;
		int w, h;
		r.status = 1'b0;
		r.rbyte = '0;
		case (cmd.func)
			FUNC_LINE: r.status = trace_line(cmd.xa, cmd.ya, cmd.xb, cmd.yb, cmd.thick, cmd.color);
			FUNC_RECT: begin
				w = cmd.xb;
				h = cmd.yb;
				if (w <= 0 || h <= 0 || cmd.xa + w > RAM_COLUMNS || cmd.ya + h > ROWS)
					r.status = 1'b1;
				else
					for (int i = 0; i < h; i++)
						for (int j = 0; j < w; j++) plot(cmd.xa + j, cmd.ya + i, cmd.color);
			end
			FUNC_SDOWN, FUNC_SUP: begin
				for (int c = 0; c < RAM_COLUMNS; c++) begin
					for (int p = 0; p < PAGES; p++) column[8*p +: 8] = shadow_store[p*RAM_COLUMNS + c];
					if (cmd.rows >= COL_BITS) column = '0;
					else if (cmd.func == FUNC_SDOWN) column = column << cmd.rows;
					else column = column >> cmd.rows;
					for (int p = 0; p < PAGES; p++) shadow_store[p*RAM_COLUMNS + c] = column[8*p +: 8];
				end
			end
			FUNC_CLEAR: foreach (shadow_store[i]) shadow_store[i] = '0;
			FUNC_READ: begin
				if (cmd.xa < RAM_COLUMNS && cmd.page < PAGES)
					r.rbyte = shadow_store[cmd.page*RAM_COLUMNS + cmd.xa];
				else
					r.status = 1'b1;
			end
			default: r.status = 1'b1;
		endcase
		return r;
	endfunction

	function automatic draw_cmd_t mk(input logic [2:0] f, input int xa, input int ya, input int xb,
		input int yb, input int th, input int c, input int rows, input int pg);
		draw_cmd_t cmd;
		cmd.func = f; cmd.xa = xa; cmd.ya = ya; cmd.xb = xb; cmd.yb = yb;
		cmd.thick = th; cmd.color = c; cmd.rows = rows; cmd.page = pg;
		cmd.typed = 0; cmd.t_status = 0; cmd.t_byte = 0;
		return cmd;
	endfunction

	function automatic draw_cmd_t typed(input draw_cmd_t cmd, input logic st, input logic [7:0] b);
		cmd.typed = 1; cmd.t_status = st; cmd.t_byte = b;
		return cmd;
	endfunction

	function automatic draw_cmd_t random_cmd();
		draw_cmd_t cmd;
		int pick;
		pick = $urandom_range(99);
		cmd = mk(FUNC_LINE, $urandom_range(127), $urandom_range(63), $urandom_range(127),
			$urandom_range(70), $urandom_range(15), $urandom_range(1), $urandom_range(40),
			$urandom_range(7));
		if (pick < 8) begin
			// wide coordinates, mostly rejected
			cmd.xa = $urandom_range(255); cmd.xb = $urandom_range(255); cmd.yb = $urandom_range(127);
		end
		if (pick < 8 && $urandom_range(1)) cmd.ya = $urandom_range(63);
		if (pick >= 45 && pick < 70) begin
			cmd.func = FUNC_RECT;
			cmd.xa = $urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(131);
			cmd.xb = $urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(40);
			cmd.yb = $urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(24);
		end else if (pick >= 70 && pick < 88) begin
			cmd.func = FUNC_READ;
			cmd.xa = $urandom_range(15) == 0 ? $urandom_range(255) : $urandom_range(131);
		end else if (pick >= 88 && pick < 96) begin
			cmd.func = $urandom_range(1) ? FUNC_SDOWN : FUNC_SUP;
			cmd.rows = $urandom_range(5) == 0 ? $urandom_range(127) : $urandom_range(12);
		end else if (pick >= 96 && pick < 97) begin
			cmd.func = FUNC_CLEAR;
		end else if (pick >= 97) begin
			cmd.func = $urandom_range(1) ? FUNC_BAD6 : FUNC_BAD7;
		end
		return cmd;
	endfunction

	// every result is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				draw_result_t want;
				want = pending_results.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (read_byte !== want.rbyte) report_mismatch("read_byte", read_byte, want.rbyte);
			end
			n_checked++;
		end
	end

	task automatic issue(input draw_cmd_t cmd, input bit calm);
		draw_result_t r;
		func <= cmd.func; x_a <= cmd.xa; y_a <= cmd.ya; x_b <= cmd.xb; y_b <= cmd.yb;
		thickness <= cmd.thick; color <= cmd.color; scroll_rows <= cmd.rows; page <= cmd.page;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		r = apply_cmd(cmd);
		if (cmd.typed) begin
			r.status = cmd.t_status;
			r.rbyte = cmd.t_byte;
		end
		pending_results.push_back(r);
		n_sent++;
		if (cmd.func == FUNC_READ) n_reads++;
		if (cmd.func == FUNC_LINE) n_lines++;
		if (r.status) n_rejects++;
		if (!calm && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	draw_cmd_t directed [$];

	initial begin
		arst_n = 0; start = 0; func = 0; x_a = 0; y_a = 0; x_b = 0; y_b = 0;
		thickness = 0; color = 0; scroll_rows = 0; page = 0;
		// the store is all zero after reset
		foreach (shadow_store[i]) shadow_store[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		directed.push_back(typed(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00));
		directed.push_back(typed(mk(FUNC_READ, 131, 0, 0, 0, 0, 0, 0, 7), 0, 8'h00));
		directed.push_back(typed(mk(FUNC_READ, 132, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_READ, 255, 0, 0, 0, 0, 0, 0, 7), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_BAD6, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_BAD7, 255, 63, 255, 127, 15, 1, 127, 7), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_LINE, 128, 0, 0, 0, 3, 1, 0, 0), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_LINE, 0, 0, 0, 127, 3, 1, 0, 0), 0, 8'h00));
		directed.push_back(typed(mk(FUNC_LINE, 0, 0, 128, 0, 3, 1, 0, 0), 1, 8'h00));
		directed.push_back(mk(FUNC_LINE, 10, 10, 10, 10, 15, 1, 0, 0));
		directed.push_back(mk(FUNC_LINE, 0, 0, 127, 63, 0, 1, 0, 0));
		directed.push_back(mk(FUNC_LINE, 127, 63, 0, 0, 15, 1, 0, 0));
		directed.push_back(mk(FUNC_LINE, 127, 5, 100, 60, 15, 0, 0, 0));
		directed.push_back(typed(mk(FUNC_RECT, 0, 0, 0, 10, 0, 1, 0, 0), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_RECT, 0, 0, 10, 0, 0, 1, 0, 0), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_RECT, 130, 0, 3, 1, 0, 1, 0, 0), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_RECT, 0, 60, 1, 5, 0, 1, 0, 0), 1, 8'h00));
		directed.push_back(typed(mk(FUNC_RECT, 0, 0, 132, 64, 0, 1, 0, 0), 0, 8'h00));
		directed.push_back(typed(mk(FUNC_READ, 5, 0, 0, 0, 0, 0, 0, 3), 0, 8'hff));
		directed.push_back(mk(FUNC_READ, 1, 0, 0, 0, 0, 0, 0, 3));
		directed.push_back(mk(FUNC_SDOWN, 0, 0, 0, 0, 0, 0, 3, 0));
		directed.push_back(mk(FUNC_SUP, 0, 0, 0, 0, 0, 0, 7, 0));
		directed.push_back(mk(FUNC_READ, 40, 0, 0, 0, 0, 0, 0, 7));
		directed.push_back(mk(FUNC_SUP, 0, 0, 0, 0, 0, 0, 64, 0));
		directed.push_back(typed(mk(FUNC_READ, 40, 0, 0, 0, 0, 0, 0, 4), 0, 8'h00));
		foreach (directed[i]) issue(directed[i], 1'b0);
		drain();

		for (int k = 0; k < N_RANDOM; k++) begin
			issue(random_cmd(), k >= N_RANDOM - CALM_TAIL);
			if (k == N_RANDOM / 2) drain();
		end
		drain();
		repeat (100) @(posedge clk);

		$display("%0d commands (%0d lines, %0d reads, %0d rejected), %0d results checked",
			n_sent, n_lines, n_reads, n_rejects, n_checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("page_framebuffer_draw_engine_top: match");
		else
			$display("page_framebuffer_draw_engine_top: mismatch");
		$finish;
	end
endmodule
